@@ hw/rtl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the sorted min priority queue
// Opcode codes, field widths, default capacity and the command that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  localparam int CAPACITY = 16;   // default number of stored values
  localparam int VALUE_W  = 32;   // width of a stored value
  localparam int COUNT_W  = 5;    // width of the count field in a result

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // Broadcast to all cells in the cycle an item is carried out.
  typedef struct packed {
    logic                      ins;    // insert value in order
    logic                      del;    // drop the front value
    logic signed [VALUE_W-1:0] value;  // value being inserted
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/smpq_if.sv @@
// ----------------------------------------------------------------------------
// smpq_if: channel interfaces of the sorted min priority queue
// Request channel (opcode, value) and response channel (status, front, count),
// both with valid/ready; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface smpq_req_if;
  logic                                valid;
  logic                                ready;
  smpq_pkg::op_e                       opcode;
  logic signed [smpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface smpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                done_res;
  logic                                is_empty;
  logic signed [smpq_pkg::VALUE_W-1:0] front_value;
  logic        [smpq_pkg::COUNT_W-1:0] count;

  modport source (output valid, output done_res, output is_empty, output front_value,
                  output count, input ready);
  modport sink   (input valid, input done_res, input is_empty, input front_value,
                  input count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sorted_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_min_priority_queue: minimum-first queue of signed 32-bit values
// Linear array of cells kept in ascending order, one operation per cycle while the response side does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : opcode OP_ENQ inserts value ahead of the first stored value that
//            is greater or equal; OP_DEQ drops the smallest value.
//   rsp_o  : one transfer per request: done_res (0 on dequeue when empty or
//            enqueue when full, state unchanged), is_empty, front_value
//            (0 when empty) and count (low 5 bits of the stored count).
// Latency: the response is valid in the cycle after the request transfer.
// Throughput: one request per cycle unless the response side stalls. Every
//   cell compares its value with the broadcast one in parallel and updates
//   at once, so the cell compare plus the front-value select set the cycle.
// Stall: the response sits in an output register; req_i.ready stays high
//   while that register is empty or being taken, and drops while the sink
//   holds rsp_o.ready low with a response pending.
// Reset: rst_ni (async, active low) empties the queue and clears the pending
//   response. Cell contents are not reset; the count alone marks live cells.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_min_priority_queue #(
  parameter int Capacity = smpq_pkg::CAPACITY
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  smpq_req_if.sink    req_i,
  smpq_rsp_if.source  rsp_o
);

  localparam int CntW = $clog2(Capacity + 1);
  localparam int VW   = smpq_pkg::VALUE_W;
  localparam int OutW = smpq_pkg::COUNT_W;

  // ---- queue occupancy ----
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty, accept;
  smpq_pkg::cell_cmd_t cmd;

  assign full   = (count_q == CntW'(Capacity));
  assign empty  = (count_q == '0);
  assign accept = req_i.valid && req_i.ready;

  // Only a request that is actually carried out moves the cells.
  assign cmd.ins   = accept && (req_i.opcode == smpq_pkg::OP_ENQ) && !full;
  assign cmd.del   = accept && (req_i.opcode == smpq_pkg::OP_DEQ) && !empty;
  assign cmd.value = req_i.value;

  assign count_d = count_q + CntW'(cmd.ins) - CntW'(cmd.del);

  // ---- cell chain ----
  // Cell 0 holds the smallest value. On insert, cells below the new value keep
  // theirs, the first other cell takes the new value, the rest shift right.
  // On delete everything shifts left by one.
  logic signed [VW-1:0] cell_val   [Capacity];
  logic signed [VW-1:0] cell_val_d [Capacity];
  logic                 cell_lt    [Capacity];
  logic                 cell_occ   [Capacity];

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                 left_lt;
    logic signed [VW-1:0] left_val, right_val;

    assign cell_occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      // nothing to the left: a non-keeping head cell always takes the new value
      assign left_lt  = 1'b1;
      assign left_val = '0;
    end else begin : g_body
      assign left_lt  = cell_lt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_val = '0;   // becomes a dead cell after a delete
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (cell_occ[i]),
      .left_lt_i   (left_lt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .lt_o        (cell_lt[i]),
      .val_o       (cell_val[i]),
      .val_d_o     (cell_val_d[i])
    );
  end

  // ---- response register ----
  logic                 rsp_valid_q;
  logic                 done_q, empty_q;
  logic signed [VW-1:0] front_q;
  logic [OutW-1:0]      cnt_q;
  logic [CntW+OutW-1:0] cnt_ext;   // zero-extended so the low bits always exist

  assign cnt_ext     = {{OutW{1'b0}}, count_d};
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q  <= cmd.ins || cmd.del;
      empty_q <= (count_d == '0);
      front_q <= (count_d == '0) ? '0 : cell_val_d[0];
      cnt_q   <= cnt_ext[OutW-1:0];
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.done_res    = done_q;
  assign rsp_o.is_empty    = empty_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.count       = cnt_q;

endmodule

`default_nettype wire

@@ hw/rtl/smpq_cell.sv @@
// ----------------------------------------------------------------------------
// smpq_cell: one storage cell of the sorted queue
// Holds one value, compares it with the broadcast value and either keeps it,
// takes the new value, or takes a neighbor's value (shift right on insert,
// shift left on delete).
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_cell (
  input  wire logic                                clk_i,
  input  wire smpq_pkg::cell_cmd_t                 cmd_i,
  input  wire logic                                occ_i,       // cell holds a live value
  input  wire logic                                left_lt_i,   // left cell stays put on insert
  input  wire logic signed [smpq_pkg::VALUE_W-1:0] left_val_i,
  input  wire logic signed [smpq_pkg::VALUE_W-1:0] right_val_i,
  output logic                                     lt_o,
  output logic signed [smpq_pkg::VALUE_W-1:0]      val_o,
  output logic signed [smpq_pkg::VALUE_W-1:0]      val_d_o
);

  logic signed [smpq_pkg::VALUE_W-1:0] val_q, val_d;

  // live and strictly below the new value: this cell keeps its value
  assign lt_o = occ_i && ($signed(val_q) < $signed(cmd_i.value));

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (lt_o) begin
        val_d = val_q;
      end else if (left_lt_i) begin
        val_d = cmd_i.value;
      end else begin
        val_d = left_val_i;
      end
    end else if (cmd_i.del) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign val_d_o = val_d;

endmodule

`default_nettype wire

@@ hw/rtl/smpq_checker.sv @@
// ----------------------------------------------------------------------------
// smpq_checker: port-level checks of the sorted min priority queue
// Watches the request and response channels and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_checker #(
  parameter int Capacity = smpq_pkg::CAPACITY
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                req_valid_i,
  input wire logic                                req_ready_i,
  input wire logic                                rsp_valid_i,
  input wire logic                                rsp_ready_i,
  input wire logic                                rsp_done_i,
  input wire logic                                rsp_empty_i,
  input wire logic signed [smpq_pkg::VALUE_W-1:0] rsp_front_i,
  input wire logic        [smpq_pkg::COUNT_W-1:0] rsp_count_i
);

  // every request transfer yields a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("no response after request transfer");

  // an empty queue reports a zero front value
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_empty_i |-> rsp_front_i == '0)
    else $error("empty queue with nonzero front value");

  // empty flag agrees with the count while the count field cannot wrap
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (Capacity < 32) |-> rsp_empty_i == (rsp_count_i == '0))
    else $error("empty flag and count disagree");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_done_i)
      && $stable(rsp_front_i) && $stable(rsp_count_i))
    else $error("stalled response changed");

endmodule

bind sorted_min_priority_queue smpq_checker #(.Capacity(Capacity)) u_smpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_done_i  (rsp_o.done_res),
  .rsp_empty_i (rsp_o.is_empty),
  .rsp_front_i (rsp_o.front_value),
  .rsp_count_i (rsp_o.count)
);

`default_nettype wire

@@ test/smpq_queue_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smpq_queue_check: scoreboard for the sorted min priority queue
// Watches both channels. Every request transfer is applied to a sorted
// shadow copy of the queue, which yields the status the block must return.
// Every response transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module smpq_queue_check import smpq_pkg::*; #(
  parameter int Capacity = CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  smpq_req_if  req,
  smpq_rsp_if  rsp,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct {
    logic                      done_res;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] front_value;
    logic        [COUNT_W-1:0] count;
  } queue_status_t;

  logic signed [VALUE_W-1:0] held_values[$];  // shadow contents, ascending
  queue_status_t             due_status[$];   // statuses still to be returned
  int                        mismatches = 0;

  // Apply one request to the shadow queue and return the status it yields.
  function automatic queue_status_t apply_request(op_e op, logic signed [VALUE_W-1:0] v);
    queue_status_t s;
    int            pos;
    s.done_res = 1'b0;
    if (op == OP_ENQ) begin
      if (held_values.size() < Capacity) begin
        // new value goes ahead of the first stored value >= it
        pos = 0;
        while (pos < held_values.size() && held_values[pos] < v) pos++;
        held_values.insert(pos, v);
        s.done_res = 1'b1;
      end
    end else if (held_values.size() > 0) begin
      void'(held_values.pop_front());
      s.done_res = 1'b1;
    end
    s.is_empty    = (held_values.size() == 0);
    s.front_value = '0;
    if (!s.is_empty) s.front_value = held_values[0];
    s.count = COUNT_W'(held_values.size());
    return s;
  endfunction

  assign fail_count_o = mismatches;

  always @(posedge clk_i) begin
    queue_status_t want;
    if (rst_ni) begin
      if (req.valid && req.ready) due_status.push_back(apply_request(req.opcode, req.value));
      if (rsp.valid && rsp.ready) begin
        if (due_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with nothing outstanding: done=%0b empty=%0b front=%0d cnt=%0d",
                     $time, rsp.done_res, rsp.is_empty, rsp.front_value, rsp.count);
        end else begin
          want = due_status.pop_front();
          if (rsp.done_res !== want.done_res || rsp.is_empty !== want.is_empty ||
              rsp.front_value !== want.front_value || rsp.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp d=%0b e=%0b f=%0d c=%0d got d=%0b e=%0b f=%0d c=%0d",
                       $time, want.done_res, want.is_empty, want.front_value, want.count,
                       rsp.done_res, rsp.is_empty, rsp.front_value, rsp.count);
          end
        end
      end
    end
    pending_o = due_status.size();
  end

endmodule

@@ test/tb_sorted_min_priority_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_min_priority_queue: testbench of the sorted min priority queue
// Drives enqueue/dequeue requests: a directed run through empty and full
// refusals, extreme and tied values, then random fill/drain/mixed bursts
// under three idling profiles, with long response hold-offs to back the
// block up. The scoreboard module and the bound checker do the checking; this top only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------

module tb_sorted_min_priority_queue;
  import smpq_pkg::*;

  localparam int ItemsPerPhase = 400;   // random requests in each idling profile

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  smpq_req_if req_ch ();
  smpq_rsp_if rsp_ch ();

  int fail_count;
  int pending;

  // Idling profile: 0 = sender 31% / receiver 72%, 1 = the reverse, 2 = none.
  // Written with nonblocking assignments so the receiver process sees a
  // change one step later, never racing with the write.
  int phase = 0;
  int req_idle_pct = 31;   // used by the sender only, so plain blocking writes

  sorted_min_priority_queue #(.Capacity(CAPACITY)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  smpq_queue_check #(.Capacity(CAPACITY)) queue_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // Values: extremes, a narrow band around zero so ties are common, and
  // full-range words so every bit toggles.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return {1'b0, {(VALUE_W-1){1'b1}}};
    if (sel == 1) return {1'b1, {(VALUE_W-1){1'b0}}};
    if (sel <= 4) return $signed($urandom_range(8)) - 4;
    return $urandom();
  endfunction

  // Offer one request. Starts and ends on a falling edge; valid gets exactly
  // one nonblocking write per falling edge, so back-to-back transfers keep
  // it high. The transfer is seen at the rising edge where ready is high.
  task automatic offer_request(input op_e op, input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.value  <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // Response side. Random idling per profile, plus hold-offs counted here:
  // a long one whenever the profile changes (the sender keeps pushing, so
  // the output register fills and the request side stalls) and rare short
  // ones at random.
  initial begin
    int stall_left;
    int seen_phase;
    stall_left     = 0;
    seen_phase     = 0;
    rsp_ch.ready   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase != seen_phase) begin
        seen_phase = phase;
        stall_left = $urandom_range(48, 96);
      end else if (stall_left == 0 && $urandom_range(999) == 0) begin
        stall_left = $urandom_range(24, 64);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (seen_phase)
          0:       rsp_ch.ready <= ($urandom_range(99) >= 72);
          1:       rsp_ch.ready <= ($urandom_range(99) >= 31);
          default: rsp_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int     sent;
    int     run_len;
    int     enq_pct;
    op_e    op;
    req_ch.valid  = 1'b0;
    req_ch.opcode = OP_ENQ;
    req_ch.value  = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: refused dequeue on empty, fill to capacity with extremes and
    // ties, refused enqueue on full, then partial drain.
    offer_request(OP_DEQ, pick_value());
    offer_request(OP_ENQ, 32'sh7FFF_FFFF);
    offer_request(OP_ENQ, 32'sh8000_0000);
    offer_request(OP_ENQ, 32'sh0000_0000);
    offer_request(OP_ENQ, -32'sd1);
    offer_request(OP_ENQ, 32'sh8000_0000);   // tie with the minimum
    offer_request(OP_ENQ, 32'sh7FFF_FFFF);   // tie with the maximum
    offer_request(OP_ENQ, 32'sd1);
    offer_request(OP_ENQ, -32'sd2);
    offer_request(OP_ENQ, 32'sd5);
    offer_request(OP_ENQ, 32'sd5);
    offer_request(OP_ENQ, 32'sh5555_5555);
    offer_request(OP_ENQ, 32'shAAAA_AAAA);
    offer_request(OP_ENQ, 32'sd3);
    offer_request(OP_ENQ, -32'sd3);
    offer_request(OP_ENQ, 32'sd100);
    offer_request(OP_ENQ, -32'sd100);        // sixteenth value: now full
    offer_request(OP_ENQ, 32'sd7);           // refused, full
    repeat (5) offer_request(OP_DEQ, pick_value());

    // Random: bursts biased toward filling, draining or balanced, so the
    // queue keeps crossing both the empty and the full boundary.
    for (int p = 0; p < 3; p++) begin
      phase <= p;
      case (p)
        0:       req_idle_pct = 31;
        1:       req_idle_pct = 72;
        default: req_idle_pct = 0;
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        run_len = $urandom_range(12, 40);
        case ($urandom_range(2))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 50;
        endcase
        repeat (run_len) begin
          op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
          offer_request(op, pick_value());
          sent++;
        end
      end
    end
    req_ch.valid <= 1'b0;

    // Drain: every status back, then a last wait for anything stray.
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sorted_min_priority_queue.f @@
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_if.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_min_priority_queue.sv
hw/rtl/smpq_checker.sv
test/smpq_queue_check.sv
test/tb_sorted_min_priority_queue.sv
